### rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Holds the operation codes, the front-to-back request struct and widths.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int unsigned DefOperandBits = 16;
  localparam int unsigned OutBits        = 33;
  localparam int unsigned RawBits        = 64;
  localparam int unsigned OpBits         = 2;
  localparam int unsigned QueueDepth     = 2;

  typedef enum logic [OpBits-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // One classified request handed from the front part to the back part.
  typedef struct packed {
    logic               zero_num;
    logic               zero_den;
    logic               neg_num;
    logic               neg_den;
    logic [RawBits-1:0] raw_num;
    logic [RawBits-1:0] mag_num;
    logic [RawBits-1:0] mag_den;
  } req_t;

endpackage

### rtl/rau_front.sv
// ----------------------------------------------------------------------------
// rau_front: raw product formation and classification
// Forms the raw numerator and denominator one request at a time, with all
// products formed in one state, and classifies the result for the back part.
// ----------------------------------------------------------------------------
module rau_front #(
  parameter int unsigned OPERAND_BITS = rau_pkg::DefOperandBits
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              op,
  input  logic [OPERAND_BITS-1:0] num_a,
  input  logic [OPERAND_BITS-1:0] den_a,
  input  logic [OPERAND_BITS-1:0] num_b,
  input  logic [OPERAND_BITS-1:0] den_b,
  output logic                    req_valid,
  input  logic                    req_ready,
  output rau_pkg::req_t           req
);
  import rau_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_SUM, S_OUT} state_t;

  state_t state;
  op_t    op_q;
  logic signed [OPERAND_BITS-1:0] an, ad, bn, bd;
  logic signed [2*OPERAND_BITS-1:0] p0, p1, p2;
  logic [RawBits-1:0] rn, rd;
  logic [RawBits-1:0] rn_next;
  logic [RawBits-1:0] p0x, p1x;

  assign in_ready  = (state == S_IDLE);
  assign req_valid = (state == S_OUT);

  assign p0x = RawBits'($signed(p0));
  assign p1x = RawBits'($signed(p1));

  always_comb begin
    unique case (op_q)
      OP_ADD:  rn_next = p0x + p1x;
      OP_SUB:  rn_next = p0x - p1x;
      OP_MUL:  rn_next = p0x;
      OP_DIV:  rn_next = p0x;
      default: rn_next = p0x;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q  <= op_t'(op);
            an    <= num_a;
            ad    <= den_a;
            bn    <= num_b;
            bd    <= den_b;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // p0: first numerator term, p1: cross term, p2: denominator.
          if (op_q == OP_MUL) begin
            p0 <= an * bn;
          end else begin
            p0 <= an * bd;
          end
          p1 <= bn * ad;
          if (op_q == OP_DIV) begin
            p2 <= ad * bn;
          end else begin
            p2 <= ad * bd;
          end
          state <= S_SUM;
        end
        S_SUM: begin
          rn    <= rn_next;
          rd    <= RawBits'($signed(p2));
          state <= S_OUT;
        end
        S_OUT: begin
          if (req_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    req.zero_num = (rn == '0);
    req.zero_den = (rd == '0);
    req.neg_num  = rn[RawBits-1];
    req.neg_den  = rd[RawBits-1];
    req.raw_num  = rn;
    req.mag_num  = rn[RawBits-1] ? (~rn + 1'b1) : rn;
    req.mag_den  = rd[RawBits-1] ? (~rd + 1'b1) : rd;
  end

endmodule

### rtl/rau_queue.sv
// ----------------------------------------------------------------------------
// rau_queue: short request queue between front and back
// A two-entry register queue that lets each side stall on its own.
// ----------------------------------------------------------------------------
module rau_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  rau_pkg::req_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output rau_pkg::req_t rd_data
);
  import rau_pkg::*;

  localparam int unsigned PtrBits = $clog2(QueueDepth);

  req_t               mem [QueueDepth];
  logic [PtrBits-1:0] wptr, rptr;
  logic [PtrBits:0]   count;
  logic               do_wr, do_rd;

  assign wr_ready = (count < (PtrBits+1)'(QueueDepth));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        mem[wptr] <= wr_data;
        wptr      <= wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (PtrBits+1)'(do_wr) - (PtrBits+1)'(do_rd);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (PtrBits+1)'(QueueDepth))
    else $error("request queue overflow");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    do_wr && !do_rd |=> count == $past(count) + 1'b1)
    else $error("request queue count did not grow on write");
  a_empty_no_read: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> !do_rd)
    else $error("read from empty request queue");
`endif

endmodule

### rtl/rau_back.sv
// ----------------------------------------------------------------------------
// rau_back: Euclidean reduction and result register
// Runs the GCD of the two magnitudes with a shared bit-serial divider, then
// divides both magnitudes by the GCD with the same unit.
// ----------------------------------------------------------------------------
module rau_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  rau_pkg::req_t                     req,
  output logic                              res_valid,
  input  logic                              res_ready,
  output logic signed [rau_pkg::OutBits-1:0] num_out,
  output logic signed [rau_pkg::OutBits-1:0] den_out,
  output logic                              status
);
  import rau_pkg::*;

  localparam int unsigned CntBits = $clog2(RawBits);

  typedef enum logic [2:0] {
    S_IDLE, S_GCD, S_DIVN, S_DIVD, S_DONE
  } state_t;

  state_t state;
  logic               neg_num, neg_den;
  logic [RawBits-1:0] mag_num, mag_den, gx, gy;
  // Shared restoring divider: dividend shifts out of quot as quotient enters.
  logic [RawBits-1:0] quot, rem, dvsr;
  logic [CntBits-1:0] cnt;
  logic               busy;
  logic [RawBits:0]   trial;
  logic [RawBits-1:0] rem_sh;
  logic [RawBits-1:0] qnum;

  assign rem_sh    = {rem[RawBits-2:0], quot[RawBits-1]};
  assign trial     = {1'b0, rem_sh} - {1'b0, dvsr};
  assign req_ready = (state == S_IDLE) && !res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      busy      <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if (busy) begin
        quot <= {quot[RawBits-2:0], ~trial[RawBits]};
        rem  <= trial[RawBits] ? rem_sh : trial[RawBits-1:0];
        cnt  <= cnt + 1'b1;
        if (cnt == CntBits'(RawBits-1)) begin
          busy <= 1'b0;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid && !res_valid) begin
            neg_num <= req.neg_num;
            neg_den <= req.neg_den;
            mag_num <= req.mag_num;
            mag_den <= req.mag_den;
            if (req.zero_num) begin
              num_out   <= '0;
              den_out   <= OutBits'(1);
              status    <= 1'b0;
              res_valid <= 1'b1;
            end else if (req.zero_den) begin
              num_out   <= req.raw_num[OutBits-1:0];
              den_out   <= '0;
              status    <= 1'b1;
              res_valid <= 1'b1;
            end else begin
              gx    <= req.mag_num;
              gy    <= req.mag_den;
              quot  <= req.mag_num;
              dvsr  <= req.mag_den;
              rem   <= '0;
              cnt   <= '0;
              busy  <= 1'b1;
              state <= S_GCD;
            end
          end
        end
        S_GCD: begin
          if (!busy) begin
            // rem holds gx mod gy; step Euclid.
            if (rem == '0) begin
              quot  <= mag_num;
              dvsr  <= gy;
              gx    <= gy;
              rem   <= '0;
              cnt   <= '0;
              busy  <= 1'b1;
              state <= S_DIVN;
            end else begin
              gx   <= gy;
              gy   <= rem;
              quot <= gy;
              dvsr <= rem;
              rem  <= '0;
              cnt  <= '0;
              busy <= 1'b1;
            end
          end
        end
        S_DIVN: begin
          if (!busy) begin
            qnum  <= quot;
            quot  <= mag_den;
            dvsr  <= gx;
            rem   <= '0;
            cnt   <= '0;
            busy  <= 1'b1;
            state <= S_DIVD;
          end
        end
        S_DIVD: begin
          if (!busy) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          num_out   <= neg_num ? OutBits'(~qnum + 1'b1) : qnum[OutBits-1:0];
          den_out   <= neg_den ? OutBits'(~quot + 1'b1) : quot[OutBits-1:0];
          status    <= 1'b0;
          res_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_not_idle: assert property (@(posedge clk) disable iff (rst)
    busy |-> state != S_IDLE && state != S_DONE)
    else $error("divider running outside a reduction step");
  a_nonzero_divisor: assert property (@(posedge clk) disable iff (rst)
    busy |-> dvsr != '0)
    else $error("divider started with zero divisor");
  a_done_gives_result: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |=> res_valid)
    else $error("reduction finished without a result");
`endif

endmodule

### rtl/rational_arith_unit.sv
// ----------------------------------------------------------------------------
// rational_arith_unit: exact arithmetic on two signed fractions
// Adds, subtracts, multiplies or divides two fractions and reduces the result
// by the Euclidean GCD of numerator and denominator magnitudes.
// ----------------------------------------------------------------------------
//
//  channel   | handshake        | payload
//  ----------+------------------+-------------------------------------------
//  request   | push / full      | op, num_a, den_a, num_b, den_b
//  result    | pop / empty      | num_out, den_out, status
//
// The front part forms the raw products in its multiply and sum states and
// hands a classified request to a two-entry queue. The back part reduces one
// request at a time with one shared 64-bit restoring divider that retires one
// quotient bit per cycle: one division per Euclid step, plus two more
// divisions by the GCD. A zero numerator or a zero denominator is answered
// from the idle state without the divider. Reset clears all control state;
// the result register holds while pop stays low, and the queue lets the front
// part accept further requests meanwhile.
// ----------------------------------------------------------------------------
module rational_arith_unit #(
  parameter int unsigned OPERAND_BITS = rau_pkg::DefOperandBits
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic [1:0]                         op,
  input  logic signed [OPERAND_BITS-1:0]     num_a,
  input  logic signed [OPERAND_BITS-1:0]     den_a,
  input  logic signed [OPERAND_BITS-1:0]     num_b,
  input  logic signed [OPERAND_BITS-1:0]     den_b,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [rau_pkg::OutBits-1:0] num_out,
  output logic signed [rau_pkg::OutBits-1:0] den_out,
  output logic                               status
);
  import rau_pkg::*;

  logic in_ready;
  logic f_valid, f_ready, b_valid, b_ready, res_valid;
  req_t f_req, b_req;

  assign full  = !in_ready;
  assign empty = !res_valid;

  rau_front #(.OPERAND_BITS(OPERAND_BITS)) u_front (
    .clk, .rst,
    .in_valid(push), .in_ready,
    .op, .num_a, .den_a, .num_b, .den_b,
    .req_valid(f_valid), .req_ready(f_ready), .req(f_req)
  );

  rau_queue u_queue (
    .clk, .rst,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_req),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_req)
  );

  rau_back u_back (
    .clk, .rst,
    .req_valid(b_valid), .req_ready(b_ready), .req(b_req),
    .res_valid, .res_ready(pop),
    .num_out, .den_out, .status
  );

`ifndef SYNTHESIS
  a_pop_clears: assert property (@(posedge clk) disable iff (rst)
    pop && !empty && !b_valid |=> empty)
    else $error("result not released after pop");
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(num_out) && $stable(den_out))
    else $error("waiting result changed");
  a_status_den: assert property (@(posedge clk) disable iff (rst)
    !empty && status |-> den_out == '0)
    else $error("error status with nonzero denominator");
`endif

endmodule
